>>> rtl/ti_pkg.sv
// ----------------------------------------------------------------------------
// Table interpolator package
// Shared types and constants for the table interpolator.
// ----------------------------------------------------------------------------
package ti_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned FRAC_W  = 17;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [CSR_IDX_W-1:0] REG_INTERP_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_FRACTION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BELOW_VALUE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ABOVE_VALUE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT   = 3'd4;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic INTERP_LINEAR = 1'b0;
   localparam logic INTERP_STEP   = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [IDX_W-1:0]   point_index;
      logic signed [VALUE_W-1:0] point_x;
      logic signed [VALUE_W-1:0] point_y;
      logic signed [VALUE_W-1:0] query_value;
      logic               query_missing;
      logic               last_query;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic               result_missing;
      logic               batch_end;
   } rsp_type;

   // Division request and response between the engine and the divider.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/ti_if.sv
// ----------------------------------------------------------------------------
// Table interpolator channel
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface ti_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ti_divider.sv
// ----------------------------------------------------------------------------
// Table interpolator divider
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module ti_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ti_pkg::div_req_type  div_req,
   output ti_pkg::div_rsp_type  div_rsp
);
   import ti_pkg::*;

   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvsr_ff, dvsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;
   logic [34:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[63]};
      diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvsr_in = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder always stays below the divisor, so 33 bits hold it.
         if (!diff[34]) begin
            rem_in  = diff[32:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = shifted[32:0];
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
endmodule

>>> rtl/ti_point_ram.sv
// ----------------------------------------------------------------------------
// Table interpolator point memory
// One write port and one registered read port holding x and y of each point.
// ----------------------------------------------------------------------------
module ti_point_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [63:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]       rd_data
);
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/ti_engine.sv
// ----------------------------------------------------------------------------
// Table interpolator engine
// Sequencer for loads and queries: bisection over the point memory and the
// final interpolation.
// ----------------------------------------------------------------------------
module ti_engine #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ti_pkg::req_type      req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ti_pkg::rsp_type      rsp,
   input  logic                 cfg_mode,
   input  logic [16:0]          cfg_frac,
   input  logic signed [31:0]   cfg_below,
   input  logic signed [31:0]   cfg_above,
   input  logic [8:0]           cfg_count,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [63:0]          wr_data,
   output logic [ADDR_W-1:0]    rd_addr,
   input  logic [63:0]          rd_data,
   output ti_pkg::div_req_type  div_req,
   input  ti_pkg::div_rsp_type  div_rsp
);
   import ti_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_BIS_WAIT, S_BIS,
      S_RD_J, S_FINAL, S_MUL, S_DIV, S_STEP_ADD, S_OUT
   } state_type;

   localparam int unsigned CW = ADDR_W + 1;

   state_type state_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic signed [31:0] v_ff, xi_ff, yi_ff, xj_ff, yj_ff;
   logic signed [31:0] res_ff;
   logic miss_ff, last_q_ff, rsp_valid_ff;
   logic neg_ff;
   logic [63:0] prod_ff;
   logic [32:0] dx_ff;
   logic signed [49:0] pa_ff, pb_ff;
   logic [CW-1:0] n_clamp, mid;
   logic [CW-1:0] rd_idx;
   logic signed [31:0] rd_x, rd_y;
   logic signed [32:0] dy;
   logic [32:0] mag, dv;
   logic [16:0] f_sat;
   logic signed [50:0] ssum;
   logic signed [50:0] sq;

   assign rd_x = rd_data[63:32];
   assign rd_y = rd_data[31:0];
   assign rd_addr = rd_idx[ADDR_W-1:0];

   always_comb begin
      if (cfg_count == '0) n_clamp = CW'(1);
      else if ({23'd0, cfg_count} > TABLE_DEPTH) n_clamp = CW'(TABLE_DEPTH);
      else n_clamp = CW'(cfg_count);
      mid = CW'(({1'b0, i_ff} + {1'b0, j_ff}) >> 1);
      dy  = {yj_ff[31], yj_ff} - {yi_ff[31], yi_ff};
      mag = dy[32] ? 33'(-dy) : 33'(dy);
      dv  = 33'({v_ff[31], v_ff} - {xi_ff[31], xi_ff});
      f_sat = (cfg_frac > ONE_Q16) ? ONE_Q16 : cfg_frac;
      ssum = 51'(pa_ff) + 51'(pb_ff);
      sq = (ssum < 0) ? -51'((-ssum) >>> 16) : (ssum >>> 16);
      rd_idx = '0;
      case (state_ff)
         S_IDLE:     rd_idx = '0;
         S_RD_FIRST: rd_idx = n_clamp - CW'(1);
         S_CHK_LAST: rd_idx = mid;
         S_BIS:      rd_idx = (v_ff < rd_x) ? mid : mid;
         default:    rd_idx = j_ff;
      endcase
      if (state_ff == S_BIS) begin
         rd_idx = CW'((({1'b0, (v_ff < rd_x) ? i_ff : mid})
                  + {1'b0, (v_ff < rd_x) ? mid : j_ff}) >> 1);
         if (v_ff < rd_x) rd_idx = (j_ff == mid) ? j_ff : rd_idx;
      end
      if (state_ff == S_BIS && !(i_ff + CW'(1) < j_ff)) rd_idx = j_ff;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign wr_en   = req_valid && req_ready && (req.mode == MODE_LOAD);
   assign wr_addr = ADDR_W'(req.point_index);
   assign wr_data = {req.point_x, req.point_y};
   assign rsp_valid = rsp_valid_ff;
   assign rsp.result_value = res_ff;
   assign rsp.result_missing = miss_ff;
   assign rsp.batch_end = last_q_ff;
   assign div_req.start    = (state_ff == S_MUL);
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = dx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready && req.mode == MODE_QUERY) begin
                  v_ff <= req.query_value;
                  last_q_ff <= req.last_query;
                  if (req.query_missing) begin
                     res_ff <= req.query_value;
                     miss_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     miss_ff <= 1'b0;
                     state_ff <= S_RD_FIRST;
                  end
               end
            end
            S_RD_FIRST: begin
               // Entry 0 is on the read port now; last entry requested.
               xi_ff <= rd_x;
               yi_ff <= rd_y;
               i_ff <= '0;
               j_ff <= n_clamp - CW'(1);
               state_ff <= S_CHK_FIRST;
            end
            S_CHK_FIRST: begin
               xj_ff <= rd_x;
               yj_ff <= rd_y;
               if (v_ff < xi_ff) begin
                  res_ff <= cfg_below;
                  state_ff <= S_OUT;
               end else if (v_ff > rd_x) begin
                  res_ff <= cfg_above;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_CHK_LAST;
               end
            end
            S_CHK_LAST: begin
               // Mid of the current interval is requested this cycle.
               state_ff <= (i_ff + CW'(1) < j_ff) ? S_BIS : S_FINAL;
            end
            S_BIS: begin
               if (!(i_ff + CW'(1) < j_ff)) begin
                  state_ff <= S_RD_J;
               end else if (v_ff < rd_x) begin
                  j_ff <= mid;
                  xj_ff <= rd_x;
                  yj_ff <= rd_y;
               end else begin
                  i_ff <= mid;
                  xi_ff <= rd_x;
                  yi_ff <= rd_y;
               end
            end
            S_RD_J: state_ff <= S_FINAL;
            S_FINAL: begin
               if (v_ff == xi_ff) begin
                  res_ff <= yi_ff;
                  state_ff <= S_OUT;
               end else if (v_ff == xj_ff) begin
                  res_ff <= yj_ff;
                  state_ff <= S_OUT;
               end else if (cfg_mode == INTERP_LINEAR) begin
                  prod_ff <= 64'(mag) * 64'(dv);
                  neg_ff <= dy[32];
                  dx_ff <= 33'({xj_ff[31], xj_ff} - {xi_ff[31], xi_ff});
                  state_ff <= S_MUL;
               end else begin
                  pa_ff <= 50'(yi_ff) * $signed({33'd0, ONE_Q16 - f_sat});
                  pb_ff <= 50'(yj_ff) * $signed({33'd0, f_sat});
                  state_ff <= S_STEP_ADD;
               end
            end
            S_MUL: state_ff <= S_DIV;
            S_DIV: begin
               if (div_rsp.done) begin
                  res_ff <= neg_ff ? 32'(yi_ff - div_rsp.quotient[31:0])
                                   : 32'(yi_ff + div_rsp.quotient[31:0]);
                  state_ff <= S_OUT;
               end
            end
            S_STEP_ADD: begin
               res_ff <= sq[31:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> rtl/table_interpolator.sv
// ----------------------------------------------------------------------------
// Table interpolator
// Piecewise linear or step interpolation over a loaded point table.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   req      in         load point or query
//   rsp      out        interpolated value, missing flag, batch end
//   csr      in         register write (index, data)
//
// A load is written to the point memory when it is taken. A query answers after
// one point memory read per bisection step plus setup and final checks; linear
// mode adds the bit-serial divider. A query outside the table answers from the
// first and last entry checks; a missing query is echoed in the cycle after it is taken.
// Reset is synchronous; the point memory is not cleared. A request is taken
// only once the previous response has been delivered.
// ----------------------------------------------------------------------------
module table_interpolator #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   ti_if.sink                                 req_ch,
   ti_if.source                               rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [ti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ti_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import ti_pkg::*;

   localparam int unsigned ADDR_W = (TABLE_DEPTH > 256) ? $clog2(TABLE_DEPTH) : 8;

   logic        mode_ff;
   logic [16:0] frac_ff;
   logic signed [31:0] below_ff, above_ff;
   logic [8:0]  count_ff;
   logic        wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [63:0] wr_data, rd_data;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        wr_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         frac_ff <= '0;
         below_ff <= '0;
         above_ff <= '0;
         count_ff <= 9'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_INTERP_MODE:   mode_ff  <= csr_write_data[0];
            REG_STEP_FRACTION: frac_ff  <= csr_write_data[16:0];
            REG_BELOW_VALUE:   below_ff <= csr_write_data;
            REG_ABOVE_VALUE:   above_ff <= csr_write_data;
            REG_POINT_COUNT:   count_ff <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   // Loads beyond the table are dropped.
   assign wr_ok = ({24'd0, req_ch.payload.point_index} < TABLE_DEPTH);

   ti_engine #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_engine (
      .clock, .reset,
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp(rsp_ch.payload),
      .cfg_mode(mode_ff), .cfg_frac(frac_ff), .cfg_below(below_ff),
      .cfg_above(above_ff), .cfg_count(count_ff),
      .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data,
      .div_req, .div_rsp
   );

   ti_point_ram #(.DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram (
      .clock, .wr_en(wr_en && wr_ok), .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   ti_divider u_div (.clock, .reset, .div_req, .div_rsp);
endmodule

>>> rtl/ti_checker.sv
// ----------------------------------------------------------------------------
// Table interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module ti_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         req_mode,
   input logic         req_missing,
   input logic         rsp_valid,
   input logic         rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken over pending response");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode && !rsp_valid |=> !rsp_valid)
      else $error("load produced a response");
   a_missing_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode && req_missing |=> rsp_valid)
      else $error("missing query not echoed next cycle");
endmodule

bind table_interpolator ti_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .req_mode(req_ch.payload.mode), .req_missing(req_ch.payload.query_missing),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Table interpolator testbench
// Loads point tables, sends interpolation queries and checks every response
// against an in-bench interpolation predictor or a directed expected value,
// over several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import ti_pkg::*;

   localparam int unsigned DEPTH = 256;
   localparam longint      ONE   = 65536;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      req_type               item;
      bit                    typed;
      rsp_type               typed_rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   ti_if #(.PAYLOAD_TYPE(req_type)) req_ch ();
   ti_if #(.PAYLOAD_TYPE(rsp_type)) rsp_ch ();

   table_interpolator #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state.
   logic signed [31:0] point_x_mem [DEPTH];
   logic signed [31:0] point_y_mem [DEPTH];
   logic               cur_mode;
   logic [16:0]        cur_fraction;
   logic signed [31:0] cur_below;
   logic signed [31:0] cur_above;
   logic [8:0]         cur_count;

   rsp_type     expected_rsp [$];
   dir_row_type directed [$];
   int          error_count  = 0;
   int          send_idle    = 0;
   int          recv_stall   = 0;
   int          hold_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("table_interpolator verification failed");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
      error_count++;
   endtask

   function automatic rsp_type interpolate(req_type r);
      rsp_type            o;
      int unsigned        n, i, j, mid;
      logic signed [31:0] v;
      longint             yi, yj, dy, s, f;
      longint unsigned    dx, dv, mag, q;
      o.batch_end      = r.last_query;
      o.result_missing = r.query_missing;
      o.result_value   = r.query_value;
      if (r.query_missing) return o;
      v = r.query_value;
      n = cur_count;
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      i = 0;
      j = n - 1;
      if (v < point_x_mem[i]) begin
         o.result_value = cur_below;
         return o;
      end
      if (v > point_x_mem[j]) begin
         o.result_value = cur_above;
         return o;
      end
      while (i + 1 < j) begin
         mid = (i + j) / 2;
         if (v < point_x_mem[mid]) j = mid;
         else i = mid;
      end
      if (v == point_x_mem[i]) begin
         o.result_value = point_y_mem[i];
         return o;
      end
      if (v == point_x_mem[j]) begin
         o.result_value = point_y_mem[j];
         return o;
      end
      yi = point_y_mem[i];
      yj = point_y_mem[j];
      if (cur_mode == INTERP_LINEAR) begin
         dy  = yj - yi;
         dx  = longint'(point_x_mem[j]) - longint'(point_x_mem[i]);
         dv  = longint'(v) - longint'(point_x_mem[i]);
         mag = (dy < 0) ? -dy : dy;
         q   = (mag * dv) / dx;
         o.result_value = (dy < 0) ? 32'(yi - longint'(q)) : 32'(yi + longint'(q));
      end else begin
         f = (cur_fraction > 17'h10000) ? ONE : longint'(cur_fraction);
         s = yi * (ONE - f) + yj * f;
         o.result_value = 32'(s / ONE);
      end
      return o;
   endfunction

   task automatic cfg_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_INTERP_MODE:   cur_mode     = data[0];
         REG_STEP_FRACTION: cur_fraction = data[16:0];
         REG_BELOW_VALUE:   cur_below    = data;
         REG_ABOVE_VALUE:   cur_above    = data;
         REG_POINT_COUNT:   cur_count    = data[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_request(req_type r, bit typed, rsp_type typed_rsp);
      csr_write_enable <= 1'b0;
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      if (r.mode == MODE_LOAD) begin
         point_x_mem[r.point_index] = r.point_x;
         point_y_mem[r.point_index] = r.point_y;
      end else begin
         expected_rsp.push_back(typed ? typed_rsp : interpolate(r));
      end
   endtask

   // Waits until every response is in, then lets a trailing load drain.
   task automatic wait_drained();
      req_ch.valid     <= 1'b0;
      csr_write_enable <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic req_type make_load(int idx, logic [31:0] x, logic [31:0] y);
      req_type r;
      r             = req_type'($urandom());
      r.query_value = $urandom();
      r.mode        = MODE_LOAD;
      r.point_index = IDX_W'(idx);
      r.point_x     = x;
      r.point_y     = y;
      return r;
   endfunction

   function automatic req_type make_query(logic [31:0] v, bit missing, bit last);
      req_type r;
      r               = '0;
      r.point_index   = IDX_W'($urandom());
      r.point_x       = $urandom();
      r.point_y       = $urandom();
      r.mode          = MODE_QUERY;
      r.query_value   = v;
      r.query_missing = missing;
      r.last_query    = last;
      return r;
   endfunction

   task automatic add_cfg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      dir_row_type d;
      d           = '{default: '0};
      d.is_cfg    = 1'b1;
      d.reg_index = idx;
      d.reg_data  = data;
      directed.push_back(d);
   endtask

   task automatic add_item(req_type r, bit typed, logic [31:0] value, bit missing, bit last);
      dir_row_type d;
      d           = '{default: '0};
      d.item      = r;
      d.typed     = typed;
      d.typed_rsp = '{result_value: value, result_missing: missing, batch_end: last};
      directed.push_back(d);
   endtask

   // Response checker and ready generator.
   initial begin
      rsp_type exp;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_ch.payload.result_value, '0);
            end else begin
               exp = expected_rsp.pop_front();
               if (rsp_ch.payload.result_value !== exp.result_value)
                  report_mismatch("result_value", rsp_ch.payload.result_value,
                                  exp.result_value);
               if (rsp_ch.payload.result_missing !== exp.result_missing)
                  report_mismatch("result_missing", 32'(rsp_ch.payload.result_missing),
                                  32'(exp.result_missing));
               if (rsp_ch.payload.batch_end !== exp.batch_end)
                  report_mismatch("batch_end", 32'(rsp_ch.payload.batch_end),
                                  32'(exp.batch_end));
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   initial begin
      req_type         r;
      rsp_type         dummy;
      int unsigned     n, k;
      longint unsigned step_span;
      logic [31:0]     v;
      int              roll;

      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      foreach (point_x_mem[a]) begin
         point_x_mem[a] = '0;
         point_y_mem[a] = '0;
      end
      cur_mode     = 1'b0;
      cur_fraction = '0;
      cur_below    = '0;
      cur_above    = '0;
      cur_count    = 9'd1;
      dummy        = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single point after reset, then the table extremes in both modes.
      add_item(make_load(0, 32'h0000_0000, 32'h0005_0000), 0, 0, 0, 0);
      add_item(make_query(32'hffff_ffff, 0, 0), 1, 32'h0, 0, 0);
      add_item(make_query(32'h0000_0001, 0, 0), 1, 32'h0, 0, 0);
      add_item(make_query(32'h0000_0000, 0, 1), 1, 32'h0005_0000, 0, 1);
      add_item(make_query(32'h8000_0000, 1, 1), 1, 32'h8000_0000, 1, 1);
      add_item(make_query(32'h7fff_ffff, 1, 0), 1, 32'h7fff_ffff, 1, 0);
      add_cfg(REG_BELOW_VALUE, 32'h8000_0000);
      add_cfg(REG_ABOVE_VALUE, 32'h7fff_ffff);
      add_cfg(REG_POINT_COUNT, 32'd4);
      add_item(make_load(1, 32'h0001_0000, 32'h7fff_ffff), 0, 0, 0, 0);
      add_item(make_load(2, 32'h0002_0000, 32'h8000_0000), 0, 0, 0, 0);
      add_item(make_load(3, 32'h7fff_ffff, 32'h0000_0000), 0, 0, 0, 0);
      add_item(make_load(255, 32'h7fff_ffff, 32'h8000_0000), 0, 0, 0, 0);
      add_item(make_query(32'h8000_0000, 0, 0), 1, 32'h8000_0000, 0, 0);
      add_item(make_query(32'h7fff_ffff, 0, 0), 1, 32'h0000_0000, 0, 0);
      add_item(make_query(32'h0001_0000, 0, 0), 1, 32'h7fff_ffff, 0, 0);
      add_item(make_query(32'h0000_8000, 0, 0), 0, 0, 0, 0);
      add_item(make_query(32'h0001_8000, 0, 0), 0, 0, 0, 0);
      add_item(make_query(32'h4000_0000, 0, 1), 0, 0, 0, 0);
      add_cfg(REG_INTERP_MODE, 32'(INTERP_STEP));
      add_cfg(REG_STEP_FRACTION, 32'h0001_0000);
      add_item(make_query(32'h0000_8000, 0, 0), 1, 32'h7fff_ffff, 0, 0);
      add_cfg(REG_STEP_FRACTION, 32'h0000_8000);
      add_item(make_query(32'h0001_8000, 0, 0), 0, 0, 0, 0);
      add_item(make_query(32'h0000_4000, 0, 1), 0, 0, 0, 0);

      foreach (directed[idx]) begin
         if (directed[idx].is_cfg) begin
            if (idx == 0 || !directed[idx-1].is_cfg) wait_drained();
            cfg_write(directed[idx].reg_index, directed[idx].reg_data);
         end else begin
            send_request(directed[idx].item, directed[idx].typed, directed[idx].typed_rsp);
         end
      end

      // Random phases: each idling pattern in both interpolation modes.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         send_idle  = (phase % 4 == 1) ? 63 : (phase % 4 == 3) ? 16 : 0;
         recv_stall = (phase % 4 == 2) ? 63 : (phase % 4 == 3) ? 16 : 0;
         case (phase)
            0: n = 256;
            1: n = 1;
            2: n = 2;
            default: n = $urandom_range(3, 16);
         endcase
         cfg_write(REG_INTERP_MODE, phase / 4);
         cfg_write(REG_STEP_FRACTION, (phase == 1) ? 32'd0 :
                   (phase == 5) ? 32'h0001_0000 : $urandom_range(0, 65536));
         cfg_write(REG_BELOW_VALUE, (phase == 2) ? 32'h7fff_ffff : $urandom());
         cfg_write(REG_ABOVE_VALUE, (phase == 2) ? 32'h8000_0000 : $urandom());
         cfg_write(REG_POINT_COUNT, n);

         // Ascending table spread over the whole value range; the last
         // phase loads an unsorted table instead.
         step_span = 64'h1_0000_0000 / n;
         for (int p = 0; p < n; p++) begin
            v = 32'(64'h8000_0000 + p * step_span + $urandom_range(0, 32'(step_span - 1)));
            if (phase == 7) v = $urandom();
            send_request(make_load(p, v, $urandom()), 0, dummy);
         end

         if (phase == 4) hold_cycles = 400;
         for (int it = 0; it < 12; it++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               // Extra loads beyond the points in use.
               k = $urandom_range(0, 255);
               if (k < n) k = n + (k % (256 - n + ((n == 256) ? 1 : 0)));
               if (k < 256 && k >= n)
                  send_request(make_load(k, $urandom(), $urandom()), 0, dummy);
            end else begin
               k = $urandom_range(0, n - 1);
               case ($urandom_range(9))
                  0, 1, 2: v = point_x_mem[k];
                  3, 4, 5: v = point_x_mem[k] + $urandom_range(1, 32'h0100_0000);
                  6, 7:    v = $urandom();
                  8:       v = 32'h8000_0000;
                  default: v = 32'h7fff_ffff;
               endcase
               send_request(make_query(v, $urandom_range(9) == 0, $urandom_range(3) == 0),
                            0, dummy);
            end
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("table_interpolator verification clean");
      end else begin
         $display("table_interpolator verification failed");
      end
      $finish;
   end

endmodule

>>> table_interpolator.f
rtl/ti_pkg.sv
rtl/ti_if.sv
rtl/ti_divider.sv
rtl/ti_point_ram.sv
rtl/ti_engine.sv
rtl/table_interpolator.sv
rtl/ti_checker.sv
test/tb_top.sv
